// ----- rtl/core/gamepad_input_remapper_core_macros.svh -----
// assertion macros for the gamepad remapper checker
// no dependencies; included by the checker file
`ifndef GAMEPAD_INPUT_REMAPPER_CORE_MACROS_SVH
`define GAMEPAD_INPUT_REMAPPER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define GRM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("grm checker: same-cycle rule violated");

// next-cycle implication, disabled during reset
`define GRM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("grm checker: next-cycle rule violated");

`endif

// ----- rtl/core/grm_pkg.sv -----
// shared types, constants and code tables for the gamepad remapper
// no dependencies
package grm_pkg;

   localparam int unsigned NUM_SRC = 24;
   localparam logic [4:0] CODE_PRESS_FIRST = 5'd4;
   localparam logic [4:0] CODE_STICK_FIRST = 5'd16;
   localparam logic [4:0] CODE_HIGH_FIRST  = 5'd20;
   localparam logic [4:0] CODE_UNMAPPED    = 5'd24;

   localparam logic [1:0] CSR_MAP_FIRST  = 2'd0;
   localparam logic [1:0] CSR_MAP_SECOND = 2'd1;
   localparam logic [1:0] CSR_DFLT_PRESS = 2'd2;
   localparam logic [1:0] CSR_DEADZONE   = 2'd3;

   localparam logic [7:0] STICK_CENTER = 8'h80;

   typedef struct packed {
      logic [15:0]  btn_in;
      logic [127:0] src;
      logic [15:0]  btn_out;
      logic [127:0] dst;
   } beat_type;

   typedef struct packed {
      logic [119:0] map;
      logic [7:0]   dflt;
      logic [6:0]   dz;
      logic [23:0]  recip_lo;
      logic [23:0]  recip_hi;
   } cfg_type;

   function automatic logic [15:0] bit_of_code(input logic [4:0] code);
      logic [15:0] b;
      case (code)
         5'd0:    b = 16'h0008;
         5'd1:    b = 16'h0001;
         5'd2:    b = 16'h0002;
         5'd3:    b = 16'h0004;
         5'd4:    b = 16'h1000;
         5'd5:    b = 16'h2000;
         5'd6:    b = 16'h4000;
         5'd7:    b = 16'h8000;
         5'd8:    b = 16'h0010;
         5'd9:    b = 16'h0020;
         5'd10:   b = 16'h0040;
         5'd11:   b = 16'h0080;
         5'd12:   b = 16'h0100;
         5'd13:   b = 16'h0200;
         5'd14:   b = 16'h0400;
         5'd15:   b = 16'h0800;
         default: b = 16'h0000;
      endcase
      return b;
   endfunction

   function automatic logic [3:0] byte_of_code(input logic [4:0] code);
      logic [3:0] y;
      case (code)
         5'd4:    y = 4'd12;
         5'd5:    y = 4'd13;
         5'd6:    y = 4'd14;
         5'd7:    y = 4'd15;
         5'd8:    y = 4'd4;
         5'd9:    y = 4'd5;
         5'd10:   y = 4'd6;
         5'd11:   y = 4'd7;
         5'd12:   y = 4'd8;
         5'd13:   y = 4'd9;
         5'd14:   y = 4'd10;
         5'd15:   y = 4'd11;
         5'd16:   y = 4'd1;
         5'd17:   y = 4'd0;
         5'd18:   y = 4'd3;
         5'd19:   y = 4'd2;
         5'd20:   y = 4'd1;
         5'd21:   y = 4'd0;
         5'd22:   y = 4'd3;
         5'd23:   y = 4'd2;
         default: y = 4'd0;
      endcase
      return y;
   endfunction

endpackage

// ----- rtl/core/grm_recip.sv -----
// restoring divider producing ceil(2^24 / d) one quotient bit a cycle
// depends on nothing; used by the remapper top level
module grm_recip (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [8:0]  divisor,
   output logic        busy,
   output logic [23:0] recip
);

   logic [24:0] num_ff, num_in;
   logic [8:0]  rem_ff, rem_in;
   logic [24:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [9:0]  trial;
   logic        take;

   assign trial = {rem_ff, num_ff[24]};
   assign take  = trial >= {1'b0, divisor};

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (start) begin
         // dividend 2^24 + d - 1 gives the ceiling
         num_in = 25'h100_0000 + {16'h0, divisor} - 25'd1;
         rem_in = 9'd0;
         quo_in = 25'd0;
         cnt_in = 5'd24;
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[23:0], 1'b0};
         rem_in = take ? 9'(trial - {1'b0, divisor}) : trial[8:0];
         quo_in = {quo_ff[23:0], take};
         cnt_in = cnt_ff - 5'd1;
         run_in = cnt_ff != 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= 5'd0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy  = run_ff;
   assign recip = quo_ff[23:0];

endmodule

// ----- rtl/core/grm_cell.sv -----
// one remapper cell: applies one source's mapping to the passing snapshot
// depends on grm_pkg
module grm_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [4:0]        src_index,
   input  grm_pkg::cfg_type  cfg,
   input  logic              in_vld,
   input  grm_pkg::beat_type in_beat,
   output logic              out_vld,
   output grm_pkg::beat_type out_beat
);

   logic              vld_ff;
   grm_pkg::beat_type beat_ff, beat_in;

   logic [4:0]  code;
   logic [3:0]  sbyte, tbyte;
   logic [7:0]  sval;
   logic        pressed, digital, low_src, low_dst, active, moved;
   logic [7:0]  den_lo, den_hi, den, num;
   logic [15:0] scaled_x;
   logic [39:0] prod;
   logic [7:0]  scaled;

   assign code    = cfg.map[7'(src_index) * 7'd5 +: 5];
   assign sbyte   = grm_pkg::byte_of_code(src_index);
   assign tbyte   = grm_pkg::byte_of_code(code);
   assign sval    = in_beat.src[{sbyte, 3'b000} +: 8];
   assign pressed = (in_beat.btn_in & grm_pkg::bit_of_code(src_index)) != 16'h0;
   assign digital = src_index < grm_pkg::CODE_PRESS_FIRST;
   assign low_src = src_index < grm_pkg::CODE_HIGH_FIRST;
   assign low_dst = code < grm_pkg::CODE_HIGH_FIRST;

   assign den_lo = 8'd128 - {1'b0, cfg.dz};
   assign den_hi = 8'd127 - {1'b0, cfg.dz};
   assign active = low_src ? (sval < den_lo)
                           : ({1'b0, sval} > 9'd128 + {2'b0, cfg.dz});
   assign moved  = low_src ? (sval < grm_pkg::STICK_CENTER)
                           : (sval > grm_pkg::STICK_CENTER);

   // round-half-up of num*255/den as (510*num + den) / (2*den)
   assign den      = low_src ? den_lo : den_hi;
   assign num      = low_src ? 8'(den_lo - sval) : 8'(sval - 8'd128 - {1'b0, cfg.dz});
   assign scaled_x = 16'(num) * 16'd510 + 16'(den);
   assign prod     = 40'(scaled_x) * 40'(low_src ? cfg.recip_lo : cfg.recip_hi);
   assign scaled   = (prod[39:24] > 16'd255) ? 8'hFF : prod[31:24];

   always_comb begin
      beat_in = in_beat;
      if (code < grm_pkg::CODE_UNMAPPED) begin
         if (src_index < grm_pkg::CODE_STICK_FIRST) begin
            if (pressed) begin
               if (code < grm_pkg::CODE_STICK_FIRST) begin
                  beat_in.btn_out = in_beat.btn_out | grm_pkg::bit_of_code(code);
                  if (code >= grm_pkg::CODE_PRESS_FIRST)
                     beat_in.dst[{tbyte, 3'b000} +: 8] = digital ? cfg.dflt : sval;
               end else if (low_dst) begin
                  beat_in.dst[{tbyte, 3'b000} +: 8] =
                     digital ? 8'h00 : 8'(grm_pkg::STICK_CENTER - {1'b0, sval[7:1]});
               end else begin
                  beat_in.dst[{tbyte, 3'b000} +: 8] =
                     digital ? 8'hFF : 8'(grm_pkg::STICK_CENTER + {1'b0, sval[7:1]});
               end
            end
         end else if (code < grm_pkg::CODE_STICK_FIRST) begin
            if (active) begin
               beat_in.btn_out = in_beat.btn_out | grm_pkg::bit_of_code(code);
               if (code >= grm_pkg::CODE_PRESS_FIRST)
                  beat_in.dst[{tbyte, 3'b000} +: 8] = scaled;
            end
         end else if (moved) begin
            beat_in.dst[{tbyte, 3'b000} +: 8] = (low_src == low_dst) ? sval : ~sval;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= in_vld;
      end
      if (advance) begin
         beat_ff <= beat_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_beat = beat_ff;

endmodule

// ----- rtl/core/gamepad_input_remapper_core.sv -----
// top level of the gamepad snapshot remapper
// depends on grm_pkg, grm_recip and grm_cell
//
// usage
//  - req_ channel carries one snapshot per beat: button bits and sixteen axis bytes
//  - rsp_ channel returns the remapped snapshot, one rsp beat for every req beat
//  - csr_ port writes the two map halves, the default pressure and the dead zone;
//    write only while no snapshot is in flight
//  - a row of 24 cells, one per source, each a register stage that applies its
//    source to the snapshot and hands it to the next
//  - throughput is one beat per cycle while the cell row is not stalled and req_ready is high
//  - the row stalls as a whole when the last cell holds a beat not yet taken;
//    req_ready drops in the same cycle, no beat is lost or duplicated
//  - the stick scaling uses two reciprocals of the dead-zone divisors, made by
//    serial dividers after reset and after each dead-zone write; req_ready is
//    low until both dividers are done
//  - reset clears all beats in flight and restores the register defaults
module gamepad_input_remapper_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_button_bits_in,
   input  logic [63:0] req_axis_bytes_low_in,
   input  logic [63:0] req_axis_bytes_high_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_button_bits_out,
   output logic [63:0] rsp_axis_bytes_low_out,
   output logic [63:0] rsp_axis_bytes_high_out,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [59:0] csr_wdata
);

   // configuration registers
   logic [59:0] map_first_ff, map_second_ff;
   logic [7:0]  dflt_ff;
   logic [6:0]  dz_ff;
   logic        recalc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_first_ff  <= '1;
         map_second_ff <= '1;
         dflt_ff       <= 8'hFF;
         dz_ff         <= 7'd0;
         recalc_ff     <= 1'b1;
      end else begin
         recalc_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               grm_pkg::CSR_MAP_FIRST:  map_first_ff  <= csr_wdata;
               grm_pkg::CSR_MAP_SECOND: map_second_ff <= csr_wdata;
               grm_pkg::CSR_DFLT_PRESS: dflt_ff       <= csr_wdata[7:0];
               grm_pkg::CSR_DEADZONE: begin
                  dz_ff     <= csr_wdata[6:0];
                  recalc_ff <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // reciprocals of 2*(128-dz) and 2*(127-dz)
   logic        busy_lo, busy_hi;
   logic [23:0] recip_lo, recip_hi;

   grm_recip u_recip_lo (
      .clock   (clock),
      .reset   (reset),
      .start   (recalc_ff),
      .divisor ({8'd128 - {1'b0, dz_ff}, 1'b0}),
      .busy    (busy_lo),
      .recip   (recip_lo)
   );

   grm_recip u_recip_hi (
      .clock   (clock),
      .reset   (reset),
      .start   (recalc_ff),
      .divisor ({8'd127 - {1'b0, dz_ff}, 1'b0}),
      .busy    (busy_hi),
      .recip   (recip_hi)
   );

   grm_pkg::cfg_type cfg;
   assign cfg.map      = {map_second_ff, map_first_ff};
   assign cfg.dflt     = dflt_ff;
   assign cfg.dz       = dz_ff;
   assign cfg.recip_lo = recip_lo;
   assign cfg.recip_hi = recip_hi;

   // whole row moves when the last stage is empty or being taken
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance && !recalc_ff && !busy_lo && !busy_hi;

   logic              stage_vld  [0:grm_pkg::NUM_SRC];
   grm_pkg::beat_type stage_beat [0:grm_pkg::NUM_SRC];

   // fresh snapshot: buttons clear, sticks centered, pressures zero
   assign stage_vld[0]          = req_valid && req_ready;
   assign stage_beat[0].btn_in  = req_button_bits_in;
   assign stage_beat[0].src     = {req_axis_bytes_high_in, req_axis_bytes_low_in};
   assign stage_beat[0].btn_out = 16'h0000;
   assign stage_beat[0].dst     = {96'h0, {4{grm_pkg::STICK_CENTER}}};

   for (genvar g = 0; g < grm_pkg::NUM_SRC; g++) begin : g_cell
      grm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .src_index (5'(g)),
         .cfg       (cfg),
         .in_vld    (stage_vld[g]),
         .in_beat   (stage_beat[g]),
         .out_vld   (stage_vld[g+1]),
         .out_beat  (stage_beat[g+1])
      );
   end

   assign rsp_valid               = stage_vld[grm_pkg::NUM_SRC];
   assign rsp_button_bits_out     = stage_beat[grm_pkg::NUM_SRC].btn_out;
   assign rsp_axis_bytes_low_out  = stage_beat[grm_pkg::NUM_SRC].dst[63:0];
   assign rsp_axis_bytes_high_out = stage_beat[grm_pkg::NUM_SRC].dst[127:64];

endmodule

// ----- rtl/core/grm_checker.sv -----
// port-level checker for the gamepad remapper, bound to the top level
// depends on grm_pkg and gamepad_input_remapper_core_macros.svh
`include "gamepad_input_remapper_core_macros.svh"

module grm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_button_bits_out,
   input logic [63:0] rsp_axis_bytes_low_out,
   input logic        csr_we,
   input logic [1:0]  csr_index
);

   // result beat waiting on the receiver
   logic rsp_stall;
   assign rsp_stall = rsp_valid && !rsp_ready;

   `GRM_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid)
   `GRM_ASSERT_NEXT(a_rsp_stable, rsp_stall, $stable({rsp_button_bits_out, rsp_axis_bytes_low_out}))
   `GRM_ASSERT_NOW(a_stall_blocks_req, rsp_stall, !req_ready)
   `GRM_ASSERT_NEXT(a_dz_write_blocks, csr_we && csr_index == grm_pkg::CSR_DEADZONE, !req_ready)

endmodule

bind gamepad_input_remapper_core grm_checker u_grm_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_ready              (req_ready),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_button_bits_out    (rsp_button_bits_out),
   .rsp_axis_bytes_low_out (rsp_axis_bytes_low_out),
   .csr_we                 (csr_we),
   .csr_index              (csr_index)
);
